// File: rtl/kmdv_pkg.sv
// Package for the k-way merge with duplicate removal and delta varint output.
// Holds the stream count, field widths, chain and status types and the sequencer states.
// No dependencies.
package kmdv_pkg;

  localparam int MAX_STREAMS = 8;
  localparam int IDX_W       = 3;
  localparam int CNT_W       = 4;
  localparam int VAL_W       = 64;
  localparam int SCAN_W      = $clog2(MAX_STREAMS);

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_REFILL = 1'b1;

  // Running minimum handed from one cell to the next.
  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value;
  } chain_t;

  // Write of one stream head or end mark into a cell.
  typedef struct packed {
    logic             en;
    logic             ended;
    logic [VAL_W-1:0] value;
  } cell_wr_t;

  typedef struct packed {
    logic valid;
    logic finished;
  } cell_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_MATCH,
    ST_VARINT,
    ST_REFILL,
    ST_DONE
  } state_t;

endpackage

// File: rtl/kmdv_cell.sv
// One merge cell: the head slot and end mark of a single stream.
// Folds its head into the running minimum and flags a match against the broadcast minimum.
// Depends on kmdv_pkg.
module kmdv_cell
  import kmdv_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cell_wr_t         wr,
  input  logic             active,
  input  logic             consume,
  input  logic [VAL_W-1:0] min_bcast,
  input  chain_t           chain_in,
  output chain_t           chain_out,
  output cell_stat_t       stat,
  output logic             match
);

  logic             valid_r;
  logic             finished_r;
  logic [VAL_W-1:0] head_r;
  chain_t           chain_r;
  chain_t           chain_nxt;
  logic             part;

  assign part = active && valid_r && !finished_r;

  always_comb begin
    if (part && (!chain_in.found || head_r < chain_in.value)) begin
      chain_nxt = '{found: 1'b1, value: head_r};
    end else begin
      chain_nxt = chain_in;
    end
  end

  assign match     = part && (head_r == min_bcast);
  assign chain_out = chain_r;
  assign stat      = '{valid: valid_r, finished: finished_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      finished_r <= 1'b0;
    end else if (wr.en) begin
      if (wr.ended) begin
        finished_r <= 1'b1;
      end else begin
        valid_r <= 1'b1;
      end
    end else if (consume && match) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    chain_r <= chain_nxt;
    if (wr.en && !wr.ended) begin
      head_r <= wr.value;
    end
  end

endmodule

// File: rtl/kmdv_top_placeholder.sv
// Refill selector: picks the lowest pending consumed stream each time a refill item is sent.
// Reports the stream index and whether it is the final pending one.
// Depends on kmdv_pkg.
module kmdv_refill_sel
  import kmdv_pkg::*;
(
  input  logic [MAX_STREAMS-1:0] pending,
  output logic [IDX_W-1:0]       idx,
  output logic [MAX_STREAMS-1:0] pending_nxt,
  output logic                   single
);

  always_comb begin
    idx = '0;
    for (int i = MAX_STREAMS - 1; i >= 0; i--) begin
      if (pending[i]) begin
        idx = IDX_W'(i);
      end
    end
  end

  assign pending_nxt = pending & (pending - MAX_STREAMS'(1));
  assign single      = (pending_nxt == '0);

endmodule

// File: rtl/kway_merge_dedup_delta_varint.sv
// Top level of the k-way merge with duplicate removal and delta varint output.
// Instantiates a row of kmdv_cell and the kmdv_refill_sel picker; depends on kmdv_pkg.
//
//   channel | direction | handshake         | payload
//   in_     | into      | in_valid/in_stall | stream_index, stream_value, stream_ended
//   out_    | out of    | out_valid/out_stall | result_kind, out_byte, refill_stream,
//           |           |                   | all_done, last
//   cfg_    | into      | cfg_wr_en         | cfg_wr_data (active streams)
//
// An ignored item leaves the sequencer idle and an incomplete one only visits the check state.
// A merge step scans the cell row while the minimum ripples through it, then sends one result
// per varint byte (up to ten, none for a duplicate) and one per refill request; the single
// output register takes one result a cycle unless stalled. Synchronous active-low reset clears
// all heads, end marks and the previous value. A stalled output holds the sequencer; no item
// is taken until the last result of the current one has entered the output register.
module kway_merge_dedup_delta_varint
  import kmdv_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [IDX_W-1:0] in_stream_index,
  input  logic [VAL_W-1:0] in_stream_value,
  input  logic             in_stream_ended,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_result_kind,
  output logic [7:0]       out_out_byte,
  output logic [IDX_W-1:0] out_refill_stream,
  output logic             out_all_done,
  output logic             out_last,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  active_r;
  logic [CNT_W-1:0]  eff;
  logic [VAL_W-1:0]  prev_r;
  logic [VAL_W-1:0]  min_r;
  logic [VAL_W-1:0]  delta_r;
  logic [SCAN_W-1:0] scan_r;
  logic [MAX_STREAMS-1:0] rem_r;

  logic             out_valid_r;
  logic             kind_r;
  logic [7:0]       byte_r;
  logic [IDX_W-1:0] stream_r;
  logic             done_r;
  logic             last_r;

  chain_t     chain_in  [MAX_STREAMS];
  chain_t     chain_out [MAX_STREAMS];
  cell_stat_t stat      [MAX_STREAMS];
  logic [MAX_STREAMS-1:0] match;
  logic [MAX_STREAMS-1:0] active;

  logic             accept;
  logic             item_ok;
  logic             out_free;
  logic             all_ready;
  logic             any_head;
  logic             scan_end;
  logic             consume;
  logic             out_load;
  logic             ld_kind;
  logic [7:0]       ld_byte;
  logic [IDX_W-1:0] ld_stream;
  logic             ld_done;
  logic             ld_last;

  logic [IDX_W-1:0]       sel_idx;
  logic [MAX_STREAMS-1:0] sel_rem_nxt;
  logic                   sel_single;

  // A zero count acts as one stream, anything above the row length as the full row.
  always_comb begin
    if (active_r == '0) begin
      eff = CNT_W'(1);
    end else if (active_r > CNT_W'(MAX_STREAMS)) begin
      eff = CNT_W'(MAX_STREAMS);
    end else begin
      eff = active_r;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_STREAMS; i++) begin
      active[i] = CNT_W'(i) < eff;
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign item_ok  = ({1'b0, in_stream_index} < eff) && !stat[in_stream_index].valid
                    && !stat[in_stream_index].finished;
  assign out_free = !out_valid_r || !out_stall;
  assign scan_end = (scan_r == SCAN_W'(MAX_STREAMS - 1));

  always_comb begin
    all_ready = 1'b1;
    any_head  = 1'b0;
    for (int i = 0; i < MAX_STREAMS; i++) begin
      if (active[i] && !stat[i].finished) begin
        if (!stat[i].valid) begin
          all_ready = 1'b0;
        end
        any_head = 1'b1;
      end
    end
  end

  assign chain_in[0] = '{found: 1'b0, value: '0};

  for (genvar g = 0; g < MAX_STREAMS; g++) begin : g_cell
    cell_wr_t wr;
    assign wr = '{en: accept && item_ok && (in_stream_index == IDX_W'(g)),
                  ended: in_stream_ended, value: in_stream_value};
    if (g > 0) begin : g_link
      assign chain_in[g] = chain_out[g-1];
    end
    kmdv_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr        (wr),
      .active    (active[g]),
      .consume   (consume),
      .min_bcast (min_r),
      .chain_in  (chain_in[g]),
      .chain_out (chain_out[g]),
      .stat      (stat[g]),
      .match     (match[g])
    );
  end

  kmdv_refill_sel u_sel (
    .pending     (rem_r),
    .idx         (sel_idx),
    .pending_nxt (sel_rem_nxt),
    .single      (sel_single)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && item_ok) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (!all_ready) begin
          state_nxt = ST_IDLE;
        end else if (!any_head) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_MATCH;
        end
      end
      ST_MATCH: begin
        state_nxt = (min_r != prev_r) ? ST_VARINT : ST_REFILL;
      end
      ST_VARINT: begin
        if (out_free && (delta_r[VAL_W-1:7] == '0)) begin
          state_nxt = ST_REFILL;
        end
      end
      ST_REFILL: begin
        if (out_free && sel_single) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    consume   = 1'b0;
    out_load  = 1'b0;
    ld_kind   = KIND_BYTE;
    ld_byte   = '0;
    ld_stream = '0;
    ld_done   = 1'b0;
    ld_last   = 1'b0;
    unique case (state_r)
      ST_MATCH: begin
        consume = 1'b1;
      end
      ST_VARINT: begin
        out_load = out_free;
        ld_byte  = {(delta_r[VAL_W-1:7] != '0), delta_r[6:0]};
      end
      ST_REFILL: begin
        out_load  = out_free;
        ld_kind   = KIND_REFILL;
        ld_stream = sel_idx;
        ld_last   = sel_single;
      end
      ST_DONE: begin
        out_load = out_free;
        ld_kind  = KIND_REFILL;
        ld_done  = 1'b1;
        ld_last  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= CNT_W'(MAX_STREAMS);
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        active_r <= cfg_wr_data;
      end
      if (state_r == ST_MATCH) begin
        prev_r <= min_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CHECK) begin
      scan_r <= '0;
    end else if (state_r == ST_SCAN) begin
      scan_r <= scan_r + SCAN_W'(1);
    end
    if ((state_r == ST_SCAN) && scan_end) begin
      min_r <= chain_out[MAX_STREAMS-1].value;
    end
    if (state_r == ST_MATCH) begin
      rem_r   <= match;
      delta_r <= min_r - prev_r;
    end else if ((state_r == ST_VARINT) && out_free) begin
      delta_r <= delta_r >> 7;
    end else if ((state_r == ST_REFILL) && out_free) begin
      rem_r <= sel_rem_nxt;
    end
    if (out_load) begin
      kind_r   <= ld_kind;
      byte_r   <= ld_byte;
      stream_r <= ld_stream;
      done_r   <= ld_done;
      last_r   <= ld_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = kind_r;
  assign out_out_byte      = byte_r;
  assign out_refill_stream = stream_r;
  assign out_all_done      = done_r;
  assign out_last          = last_r;

endmodule
